FILE: design/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

  // Parser phases within one record line.
  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_LEN  = 4'd1,
    PH_ADDR = 4'd2,
    PH_TYPE = 4'd3,
    PH_BASE = 4'd4,
    PH_DATA = 4'd5,
    PH_SUM  = 4'd6,
    PH_SKIP = 4'd7
  } phase_t;

  // Result kinds on the output channel.
  typedef enum logic [2:0] {
    K_WRITE  = 3'd0,
    K_DATA   = 3'd1,
    K_BASE   = 3'd2,
    K_IGNORE = 3'd3,
    K_ERROR  = 3'd4
  } kind_t;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_BASE  = 8'h04;
  localparam logic       MODE_EOL   = 1'b1;

  // One result word as it leaves the parser.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [7:0]  length;
  } result_t;

  // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/ihex_parser.sv
`default_nettype none

module ihex_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             mode,
  input  wire logic [7:0]       ch,
  output ihex_pkg::result_t     res
);

  ihex_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        nibble_second_r, nibble_second_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  record_len_r, record_len_nxt;
  logic [15:0] record_addr_r, record_addr_nxt;
  logic [7:0]  record_type_r, record_type_nxt;
  logic [15:0] base_value_r, base_value_nxt;
  logic [15:0] upper_address_r, upper_address_nxt;

  logic [4:0]  hex;
  logic [7:0]  byte_val;
  logic [7:0]  sum_new;
  logic [7:0]  count_inc;

  assign hex       = ihex_pkg::hex_decode(ch);
  assign byte_val  = {high_nibble_r, hex[3:0]};
  assign sum_new   = running_sum_r + byte_val;
  assign count_inc = byte_count_r + 8'd1;

  // State registers, updated only when a word is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= ihex_pkg::PH_WAIT;
      high_nibble_r   <= '0;
      nibble_second_r <= 1'b0;
      byte_count_r    <= '0;
      running_sum_r   <= '0;
      record_len_r    <= '0;
      record_addr_r   <= '0;
      record_type_r   <= '0;
      base_value_r    <= '0;
      upper_address_r <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      high_nibble_r   <= high_nibble_nxt;
      nibble_second_r <= nibble_second_nxt;
      byte_count_r    <= byte_count_nxt;
      running_sum_r   <= running_sum_nxt;
      record_len_r    <= record_len_nxt;
      record_addr_r   <= record_addr_nxt;
      record_type_r   <= record_type_nxt;
      base_value_r    <= base_value_nxt;
      upper_address_r <= upper_address_nxt;
    end
  end

  // Next state and result for the word at the input.
  always_comb begin
    phase_nxt         = phase_r;
    high_nibble_nxt   = high_nibble_r;
    nibble_second_nxt = nibble_second_r;
    byte_count_nxt    = byte_count_r;
    running_sum_nxt   = running_sum_r;
    record_len_nxt    = record_len_r;
    record_addr_nxt   = record_addr_r;
    record_type_nxt   = record_type_r;
    base_value_nxt    = base_value_r;
    upper_address_nxt = upper_address_r;
    res               = '0;
    res.kind          = ihex_pkg::K_ERROR;

    if (mode == ihex_pkg::MODE_EOL) begin
      // End of line: an empty line or an unfinished record is an error.
      phase_nxt         = ihex_pkg::PH_WAIT;
      nibble_second_nxt = 1'b0;
      res.valid         = (phase_r != ihex_pkg::PH_SKIP);
    end else begin
      case (phase_r)
        ihex_pkg::PH_SKIP: begin
          res.valid = 1'b0;
        end
        ihex_pkg::PH_WAIT: begin
          if (ch != ihex_pkg::CH_COLON) begin
            phase_nxt = ihex_pkg::PH_SKIP;
            res.valid = 1'b1;
          end else begin
            phase_nxt         = ihex_pkg::PH_LEN;
            running_sum_nxt   = '0;
            byte_count_nxt    = '0;
            nibble_second_nxt = 1'b0;
            record_addr_nxt   = '0;
            base_value_nxt    = '0;
          end
        end
        ihex_pkg::PH_LEN, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE,
        ihex_pkg::PH_BASE, ihex_pkg::PH_DATA, ihex_pkg::PH_SUM: begin
          if (!hex[4]) begin
            phase_nxt         = ihex_pkg::PH_SKIP;
            nibble_second_nxt = 1'b0;
            res.valid         = 1'b1;
          end else if (!nibble_second_r) begin
            high_nibble_nxt   = hex[3:0];
            nibble_second_nxt = 1'b1;
          end else begin
            // A full byte is complete.
            nibble_second_nxt = 1'b0;
            running_sum_nxt   = sum_new;
            case (phase_r)
              ihex_pkg::PH_LEN: begin
                record_len_nxt = byte_val;
                byte_count_nxt = '0;
                phase_nxt      = ihex_pkg::PH_ADDR;
              end
              ihex_pkg::PH_ADDR: begin
                record_addr_nxt = {record_addr_r[7:0], byte_val};
                byte_count_nxt  = count_inc;
                if (count_inc >= 8'd2) begin
                  phase_nxt = ihex_pkg::PH_TYPE;
                end
              end
              ihex_pkg::PH_TYPE: begin
                record_type_nxt = byte_val;
                byte_count_nxt  = '0;
                if (byte_val == ihex_pkg::TYPE_BASE) begin
                  phase_nxt = ihex_pkg::PH_BASE;
                end else if (byte_val == ihex_pkg::TYPE_DATA) begin
                  phase_nxt = (record_len_r != 8'd0) ? ihex_pkg::PH_DATA
                                                     : ihex_pkg::PH_SUM;
                end else begin
                  phase_nxt = ihex_pkg::PH_SKIP;
                  res.valid = 1'b1;
                  res.kind  = ihex_pkg::K_IGNORE;
                end
              end
              ihex_pkg::PH_BASE: begin
                base_value_nxt = {base_value_r[7:0], byte_val};
                byte_count_nxt = count_inc;
                if (count_inc >= 8'd2) begin
                  upper_address_nxt = {base_value_r[7:0], byte_val};
                  phase_nxt         = ihex_pkg::PH_SUM;
                end
              end
              ihex_pkg::PH_DATA: begin
                byte_count_nxt = count_inc;
                if (count_inc >= record_len_r) begin
                  phase_nxt = ihex_pkg::PH_SUM;
                end
                res.valid   = 1'b1;
                res.kind    = ihex_pkg::K_WRITE;
                res.address = {upper_address_r, record_addr_r} + {24'd0, byte_count_r};
                res.data    = byte_val;
              end
              default: begin
                // Checksum byte closes the record.
                phase_nxt = ihex_pkg::PH_SKIP;
                res.valid = 1'b1;
                if (sum_new != 8'd0) begin
                  res.kind = ihex_pkg::K_ERROR;
                end else if (record_type_r == ihex_pkg::TYPE_BASE) begin
                  res.kind = ihex_pkg::K_BASE;
                end else begin
                  res.kind   = ihex_pkg::K_DATA;
                  res.length = record_len_r;
                end
              end
            endcase
          end
        end
        default: begin
          // Undefined phase codes recover through an error.
          phase_nxt = ihex_pkg::PH_SKIP;
          res.valid = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/ihex_out_reg.sv
`default_nettype none

module ihex_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire ihex_pkg::result_t res,
  output logic               ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ihex_pkg::result_t  out_res
);

  logic              valid_r, valid_nxt;
  ihex_pkg::result_t res_r;

  // The slot takes a new word when empty or being drained this cycle.
  assign ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = res.valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads only with a result.
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: design/intel_hex_record_decoder.sv
// Intel HEX record decoder.
// Input channel: one word per character of a record line. in_tuser is the
// mode flag (0 = character in in_tdata, 1 = end of line); in_tdata[7:0] is
// the ASCII character.
// Output channel: zero or one result word per input word. out_tuser is the
// result kind (write, data record ok, base record ok, ignored type, error);
// out_tdata carries the write address, the data byte and the record length.
// Each result is registered and shows in the cycle after the word that causes it.
// Throughput: one input word per cycle while the output slot can take it; the parser
// state and output register are each one register stage with one short path between.
// Reset clears the parser to wait for a colon, the upper address to zero
// and empties the output register.
// When the receiver stalls, the output register holds its word and in_tready
// drops. in_tready is high whenever that register is empty or drains in the
// same cycle, so a held word that waits also holds back input words that
// would cause no result.
`default_nettype none

module intel_hex_record_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] address, [39:32] data, [47:40] length
  output logic [2:0]       out_tuser   // [2:0] kind
);

  logic              accept;
  logic              slot_ready;
  ihex_pkg::result_t res;
  ihex_pkg::result_t out_res;

  assign in_tready = slot_ready;
  assign accept    = in_tvalid && slot_ready;

  // Character parser with record state.
  ihex_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .mode   (in_tuser),
    .ch     (in_tdata),
    .res    (res)
  );

  // Result register.
  ihex_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .res       (res),
    .ready     (slot_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.length, out_res.data, out_res.address};
  assign out_tuser = out_res.kind;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ihex_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_WORDS = 1300;
  localparam int LONG_HOLD = 400;

  // One word on the character channel.
  typedef struct {
    logic       mode;
    logic [7:0] ch;
  } char_word_t;

  // One result word as the parser should produce it.
  typedef struct {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [7:0]  length;
  } parse_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;

  char_word_t    char_words[$];
  parse_result_t awaited_results[$];
  logic [7:0]    rec_bytes[$];
  logic [7:0]    line_chars[$];

  int words_accepted = 0;
  int total_words = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Shadow copy of the parser state.
  phase_t      ps_phase = PH_WAIT;
  logic [3:0]  ps_high = 4'd0;
  logic        ps_second = 1'b0;
  logic [7:0]  ps_count = 8'd0;
  logic [7:0]  ps_sum = 8'd0;
  logic [7:0]  ps_len = 8'd0;
  logic [15:0] ps_addr = 16'd0;
  logic [7:0]  ps_type = 8'd0;
  logic [15:0] ps_base = 16'd0;
  logic [15:0] ps_upper = 16'd0;

  intel_hex_record_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Traffic shaping: 0 = slow receiver, 1 = slow sender, 2 = full speed.
  function automatic int traffic_stage();
    if (words_accepted < total_words / 3) return 0;
    if (words_accepted < (2 * total_words) / 3) return 1;
    return 2;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    if ($urandom_range(0, 1)) return "A" + 8'(n) - 8'd10;
    return "a" + 8'(n) - 8'd10;
  endfunction

  task automatic await_result(input kind_t k, input logic [31:0] a, input logic [7:0] d,
                              input logic [7:0] l);
    parse_result_t r;
    r.kind = k;
    r.address = a;
    r.data = d;
    r.length = l;
    awaited_results.push_back(r);
  endtask

  // Advances the shadow parser by one accepted word.
  task automatic parse_word(input logic mode, input logic [7:0] c);
    phase_t     was;
    logic [4:0] dig;
    logic [7:0] b;
    if (mode == MODE_EOL) begin
      was = ps_phase;
      ps_phase = PH_WAIT;
      ps_second = 1'b0;
      if (was != PH_SKIP) await_result(K_ERROR, 32'd0, 8'd0, 8'd0);
      return;
    end
    if (ps_phase == PH_SKIP) return;
    if (ps_phase == PH_WAIT) begin
      if (c != CH_COLON) begin
        ps_phase = PH_SKIP;
        await_result(K_ERROR, 32'd0, 8'd0, 8'd0);
        return;
      end
      ps_phase = PH_LEN;
      ps_sum = 8'd0;
      ps_count = 8'd0;
      ps_second = 1'b0;
      ps_addr = 16'd0;
      ps_base = 16'd0;
      return;
    end
    dig = digit_of(c);
    if (!dig[4]) begin
      ps_phase = PH_SKIP;
      ps_second = 1'b0;
      await_result(K_ERROR, 32'd0, 8'd0, 8'd0);
      return;
    end
    if (!ps_second) begin
      ps_high = dig[3:0];
      ps_second = 1'b1;
      return;
    end
    ps_second = 1'b0;
    b = {ps_high, dig[3:0]};
    ps_sum = ps_sum + b;
    case (ps_phase)
      PH_LEN: begin
        ps_len = b;
        ps_count = 8'd0;
        ps_phase = PH_ADDR;
      end
      PH_ADDR: begin
        ps_addr = {ps_addr[7:0], b};
        ps_count = ps_count + 8'd1;
        if (ps_count >= 8'd2) ps_phase = PH_TYPE;
      end
      PH_TYPE: begin
        ps_type = b;
        ps_count = 8'd0;
        if (b == TYPE_BASE) begin
          ps_phase = PH_BASE;
        end else if (b == TYPE_DATA) begin
          ps_phase = (ps_len != 8'd0) ? PH_DATA : PH_SUM;
        end else begin
          ps_phase = PH_SKIP;
          await_result(K_IGNORE, 32'd0, 8'd0, 8'd0);
        end
      end
      PH_BASE: begin
        ps_base = {ps_base[7:0], b};
        ps_count = ps_count + 8'd1;
        if (ps_count >= 8'd2) begin
          ps_upper = ps_base;
          ps_phase = PH_SUM;
        end
      end
      PH_DATA: begin
        await_result(K_WRITE, {ps_upper, ps_addr} + {24'd0, ps_count}, b, 8'd0);
        ps_count = ps_count + 8'd1;
        if (ps_count >= ps_len) ps_phase = PH_SUM;
      end
      default: begin
        ps_phase = PH_SKIP;
        if (ps_sum != 8'd0) await_result(K_ERROR, 32'd0, 8'd0, 8'd0);
        else if (ps_type == TYPE_BASE) await_result(K_BASE, 32'd0, 8'd0, 8'd0);
        else await_result(K_DATA, 32'd0, 8'd0, ps_len);
      end
    endcase
  endtask

  task automatic push_char(input logic [7:0] c);
    char_word_t w;
    w.mode = 1'b0;
    w.ch = c;
    char_words.push_back(w);
  endtask

  // The end-of-line word carries a random, ignored character.
  task automatic push_eol();
    char_word_t w;
    w.mode = MODE_EOL;
    w.ch = 8'($urandom_range(0, 255));
    char_words.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Turns rec_bytes into a record line, appending a checksum that is off by
  // sum_error.
  task automatic encode_record(input logic [7:0] sum_error);
    logic [7:0] total;
    total = 8'd0;
    foreach (rec_bytes[i]) total = total + rec_bytes[i];
    rec_bytes.push_back(8'd0 - total + sum_error);
    line_chars = {};
    line_chars.push_back(CH_COLON);
    foreach (rec_bytes[i]) begin
      line_chars.push_back(digit_char(rec_bytes[i][7:4]));
      line_chars.push_back(digit_char(rec_bytes[i][3:0]));
    end
  endtask

  // Builds one random line: mostly well-formed records, some broken ones.
  task automatic make_random_line(input int line_no);
    int         sel;
    int         n;
    logic [7:0] len;
    logic [15:0] addr;
    logic [15:0] base;
    logic [7:0] rtype;
    logic [7:0] sum_error;
    rec_bytes = {};
    sel = $urandom_range(0, 99);
    sum_error = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(1, 255)) : 8'd0;
    if (sel < 50) begin
      len = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(7, 40));
      if (line_no == 12) len = 8'd255;
      addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 4))
                                         : 16'($urandom_range(0, 65535));
      rec_bytes = {len, addr[15:8], addr[7:0], TYPE_DATA};
      for (int i = 0; i < len; i++) rec_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 75) begin
      n = $urandom_range(0, 9);
      base = (n < 2) ? 16'hFFFF : (n < 3) ? 16'h0000 : 16'($urandom_range(0, 65535));
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd2;
      rec_bytes = {len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), TYPE_BASE,
                   base[15:8], base[7:0]};
    end else begin
      do rtype = 8'($urandom_range(0, 255));
      while (rtype == TYPE_DATA || rtype == TYPE_BASE);
      len = 8'($urandom_range(0, 4));
      rec_bytes = {len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rtype};
      for (int i = 0; i < len; i++) rec_bytes.push_back(8'($urandom_range(0, 255)));
    end
    encode_record(sum_error);

    // Damage about one line in five.
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, line_chars.size() - 1)) void'(line_chars.pop_back());
        1: line_chars[$urandom_range(1, line_chars.size() - 1)] = 8'($urandom_range(0, 255));
        2: line_chars[0] = 8'($urandom_range(0, 255));
        default: line_chars = {};
      endcase
    end
    foreach (line_chars[i]) push_char(line_chars[i]);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)));
    end
    push_eol();
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stimulus, reset and end of run.
  initial begin
    int line_no;
    // Empty line, missing colon, short line, bad digit, base record at the top.
    push_eol();
    push_text("z");
    push_eol();
    push_text(":1");
    push_eol();
    push_text(":x");
    push_eol();
    push_text(":02000004ffFFfc");
    push_eol();
    line_no = 0;
    while (char_words.size() < TARGET_WORDS) begin
      make_random_line(line_no);
      line_no++;
    end
    total_words = char_words.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (char_words.size() != 0 || in_tvalid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Driver: offers the queued words and feeds each accepted one to the shadow parser.
  always @(posedge clk) begin : drive_words
    char_word_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_word(in_tuser, in_tdata);
        words_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (char_words.size() != 0 &&
            $urandom_range(0, 99) >= ((traffic_stage() == 1) ? 48 :
                                      (traffic_stage() == 0) ? 14 : 0)) begin
          w = char_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= w.ch;
          in_tuser <= w.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest awaited one.
  always @(posedge clk) begin : check_results
    parse_result_t r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d tdata %h", $time, out_tuser, out_tdata);
          error_count++;
        end else begin
          r = awaited_results.pop_front();
          if (out_tuser != r.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, r.kind, out_tuser);
            error_count++;
          end
          if (out_tdata[31:0] != r.address) begin
            $display("%0t: address expected %h actual %h", $time, r.address, out_tdata[31:0]);
            error_count++;
          end
          if (out_tdata[39:32] != r.data) begin
            $display("%0t: data expected %h actual %h", $time, r.data, out_tdata[39:32]);
            error_count++;
          end
          if (out_tdata[47:40] != r.length) begin
            $display("%0t: length expected %0d actual %0d", $time, r.length, out_tdata[47:40]);
            error_count++;
          end
        end
      end

      // One long hold-off at full speed lets the block back up into its input.
      if (!hold_done && traffic_stage() == 2) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= ((traffic_stage() == 0) ? 48 :
                                                 (traffic_stage() == 1) ? 14 : 0));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
